// ===== hdl/assert_macros.svh =====
// Assertion helpers for the m3i block. Clock and reset come from the
// module that uses them: clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define M3I_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("m3i assertion failed");

// checked during reset as well
`define M3I_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("m3i assertion failed");

`endif

// ===== hdl/m3i_pkg.sv =====
package m3i_pkg;

  localparam int unsigned ELEM      = 9;
  localparam int unsigned EW        = 32;   // element width
  localparam int unsigned CW        = 64;   // cofactor width
  localparam int unsigned DW        = 98;   // determinant width, signed
  localparam int unsigned MW        = DW - 1; // determinant magnitude
  localparam int unsigned DIV_STEPS = 33;   // quotient bits below the overflow test
  localparam int unsigned QW        = DIV_STEPS;
  localparam int unsigned RW        = MW + DIV_STEPS; // partial remainder width
  localparam int unsigned FRONT_LAT = 5;
  localparam int unsigned LANE_LAT  = DIV_STEPS + 2;
  localparam int unsigned TOTAL_LAT = FRONT_LAT + LANE_LAT;

  localparam logic [EW-1:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [EW-1:0] LIM_NEG = 32'h8000_0000;

  // adj[k] = a[i0]*a[i1] - a[i2]*a[i3]
  localparam int unsigned COF_IDX [ELEM][4] = '{
    '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
    '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
    '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
  };

  typedef struct packed {
    logic [CW-1:0] mag;   // |cofactor|
    logic          neg;   // sign of the quotient
    logic [MW-1:0] dmag;  // |det|
  } lane_in_t;

  typedef struct packed {
    logic [EW-1:0] r;
    logic          sat;
  } lane_out_t;

endpackage

// ===== hdl/matrix3x3_inverse.sv =====
// matrix3x3_inverse: inverse of a 3x3 Q16.16 matrix by adjugate / determinant
//
//  channel | signals                                  | dir | word
//  --------+------------------------------------------+-----+---------------------------
//  in      | in_valid_i in_ready_o a00_i..a22_i       | in  | row-major matrix A
//  out     | out_valid_o out_ready_i r00_o..r22_o     | out | row-major inverse, flags
//          | singular_o saturated_o                   |     |
//
//  One word accepted per cycle while the output is not stalled. A result is
//  offered at the end of 40 register stages: 5 front stages for products,
//  cofactors and determinant, then 35 stages of the per-element divider: an
//  input stage, one quotient bit per step stage, and a rounding stage.
//  Reset clears only the valid bits; data registers are not reset.
//  A stall at the output freezes the whole pipeline in place; in_ready_o then
//  drops, and nothing is lost or repeated.
module matrix3x3_inverse (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] a00_i,
  input  logic [31:0] a01_i,
  input  logic [31:0] a02_i,
  input  logic [31:0] a10_i,
  input  logic [31:0] a11_i,
  input  logic [31:0] a12_i,
  input  logic [31:0] a20_i,
  input  logic [31:0] a21_i,
  input  logic [31:0] a22_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] r00_o,
  output logic [31:0] r01_o,
  output logic [31:0] r02_o,
  output logic [31:0] r10_o,
  output logic [31:0] r11_o,
  output logic [31:0] r12_o,
  output logic [31:0] r20_o,
  output logic [31:0] r21_o,
  output logic [31:0] r22_o,
  output logic        singular_o,
  output logic        saturated_o
);

  `include "assert_macros.svh"

  localparam int unsigned NE  = m3i_pkg::ELEM;
  localparam int unsigned LAT = m3i_pkg::TOTAL_LAT;
  localparam int unsigned LL  = m3i_pkg::LANE_LAT;
  localparam int unsigned CW  = m3i_pkg::CW;
  localparam int unsigned DW  = m3i_pkg::DW;

  // Pipeline moves as a whole whenever the last stage is empty or drained.
  logic adv;
  logic v_q [LAT];

  assign adv        = !v_q[LAT-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) v_q[k] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= in_valid_i;
      for (int k = 1; k < LAT; k++) v_q[k] <= v_q[k-1];
    end
  end

  logic signed [31:0] a_in [NE];
  assign a_in = '{a00_i, a01_i, a02_i, a10_i, a11_i, a12_i, a20_i, a21_i, a22_i};

  // S1: the 18 cofactor products, 32x32 each
  logic signed [CW-1:0] pp_q [NE][2];
  logic signed [31:0]   a0s1_q [3];
  logic signed [31:0]   a0s2_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NE; k++) begin
        pp_q[k][0] <= a_in[m3i_pkg::COF_IDX[k][0]] * a_in[m3i_pkg::COF_IDX[k][1]];
        pp_q[k][1] <= a_in[m3i_pkg::COF_IDX[k][2]] * a_in[m3i_pkg::COF_IDX[k][3]];
      end
      for (int j = 0; j < 3; j++) a0s1_q[j] <= a_in[j];
    end
  end

  // S2: cofactors (adjugate elements, Q32.32)
  logic signed [CW-1:0] cof2_q [NE];
  logic signed [CW-1:0] cof3_q [NE];
  logic signed [CW-1:0] cof4_q [NE];
  logic signed [CW-1:0] cof5_q [NE];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NE; k++) cof2_q[k] <= pp_q[k][0] - pp_q[k][1];
      for (int j = 0; j < 3; j++) a0s2_q[j] <= a0s1_q[j];
    end
  end

  // S3: row 0 times adjugate column 0, each 32x64 split into two 32x32 halves
  logic signed [64:0] pl_q [3];
  logic signed [63:0] ph_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        pl_q[j] <= a0s2_q[j] * $signed({1'b0, cof2_q[3*j][31:0]});
        ph_q[j] <= a0s2_q[j] * $signed(cof2_q[3*j][63:32]);
      end
      cof3_q <= cof2_q;
    end
  end

  // S4: recombine halves; S5: cofactor expansion sum along row 0
  logic signed [DW-1:0] term_q [3];
  logic signed [DW-1:0] det_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        term_q[j] <= (DW'(ph_q[j]) <<< 32) + DW'(pl_q[j]);
      end
      cof4_q <= cof3_q;
      det_q  <= term_q[0] + term_q[1] + term_q[2];
      cof5_q <= cof4_q;
    end
  end

  // magnitudes and signs into the divider lanes
  logic [DW-1:0]             det_neg;
  logic                      dneg;
  logic                      sing_d;
  m3i_pkg::lane_in_t         lane_in  [NE];
  m3i_pkg::lane_out_t        lane_out [NE];

  always_comb begin
    det_neg = DW'(0) - det_q;
    dneg    = det_q[DW-1];
    sing_d  = det_q == '0;
    for (int k = 0; k < NE; k++) begin
      lane_in[k].mag  = cof5_q[k][CW-1] ? CW'(0) - cof5_q[k] : cof5_q[k];
      lane_in[k].neg  = cof5_q[k][CW-1] ^ dneg;
      lane_in[k].dmag = dneg ? det_neg[DW-2:0] : det_q[DW-2:0];
    end
  end

  for (genvar k = 0; k < NE; k++) begin : g_lane
    m3i_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (adv),
      .lane_i (lane_in[k]),
      .lane_o (lane_out[k])
    );
  end

  // singular flag rides alongside the divider
  logic sg_q [LL];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sg_q[0] <= sing_d;
      for (int k = 1; k < LL; k++) sg_q[k] <= sg_q[k-1];
    end
  end

  logic [31:0] r_out [NE];
  logic        any_sat;

  always_comb begin
    any_sat = 1'b0;
    for (int k = 0; k < NE; k++) begin
      r_out[k] = sg_q[LL-1] ? 32'h0 : lane_out[k].r;
      any_sat  = any_sat | lane_out[k].sat;
    end
  end

  assign out_valid_o = v_q[LAT-1];
  assign singular_o  = sg_q[LL-1];
  assign saturated_o = !sg_q[LL-1] && any_sat;
  assign r00_o = r_out[0];
  assign r01_o = r_out[1];
  assign r02_o = r_out[2];
  assign r10_o = r_out[3];
  assign r11_o = r_out[4];
  assign r12_o = r_out[5];
  assign r20_o = r_out[6];
  assign r21_o = r_out[7];
  assign r22_o = r_out[8];

  `M3I_ASSERT(a_accept_enters, in_valid_i && in_ready_o |=> v_q[0])
  `M3I_ASSERT(a_sing_zero, out_valid_o && singular_o |-> !saturated_o && r11_o == 32'h0)
  `M3I_ASSERT_ALWAYS(a_empty_ready, !out_valid_o |-> in_ready_o)

endmodule

// ===== hdl/m3i_div_lane.sv =====
// Restoring divider, one quotient bit per stage: round(mag * 2^32 / dmag),
// clamped and signed.
module m3i_div_lane (
  input  logic                clk_i,
  input  logic                en_i,
  input  m3i_pkg::lane_in_t   lane_i,
  output m3i_pkg::lane_out_t  lane_o
);

  localparam int unsigned RW = m3i_pkg::RW;
  localparam int unsigned QW = m3i_pkg::QW;
  localparam int unsigned NS = m3i_pkg::DIV_STEPS;

  logic [RW-1:0]          rem_q [NS+1];
  logic [m3i_pkg::MW-1:0] d_q   [NS+1];
  logic                   neg_q [NS+1];
  logic                   ovf_q [1:NS];
  logic [QW-1:0]          q_q   [1:NS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'({lane_i.mag, 32'h0});
      d_q[0]   <= lane_i.dmag;
      neg_q[0] <= lane_i.neg;
    end
  end

  for (genvar j = 1; j <= NS; j++) begin : g_step
    localparam int unsigned Sh = NS - j;
    logic [RW-1:0] dsh;
    logic          take;
    assign dsh  = RW'(d_q[j-1]) << Sh;
    assign take = rem_q[j-1] >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= take ? rem_q[j-1] - dsh : rem_q[j-1];
        d_q[j]   <= d_q[j-1];
        neg_q[j] <= neg_q[j-1];
      end
    end

    if (j == 1) begin : g_first
      // quotient of 2^33 or more saturates in any case
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ovf_q[j] <= rem_q[0] >= (RW'(d_q[0]) << NS);
          q_q[j]   <= QW'(take);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          ovf_q[j] <= ovf_q[j-1];
          q_q[j]   <= {q_q[j-1][QW-2:0], take};
        end
      end
    end
  end

  logic [RW-1:0]   two_rem;
  logic            rnd;
  logic [QW:0]     q1;
  logic [QW:0]     lim;
  logic            sat;
  logic [31:0]     val;
  m3i_pkg::lane_out_t res_d, res_q;

  always_comb begin
    two_rem   = {rem_q[NS][RW-2:0], 1'b0};
    rnd       = two_rem >= RW'(d_q[NS]);
    q1        = {1'b0, q_q[NS]} + (QW+1)'(rnd);
    lim       = neg_q[NS] ? (QW+1)'(m3i_pkg::LIM_NEG) : (QW+1)'(m3i_pkg::LIM_POS);
    sat       = ovf_q[NS] || (q1 > lim);
    val       = sat ? lim[31:0] : q1[31:0];
    res_d.r   = neg_q[NS] ? 32'h0 - val : val;
    res_d.sat = sat;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign lane_o = res_q;

endmodule

// ===== test/matrix_inverse_checker.sv =====
module matrix_inverse_checker (
  input  logic        clk_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] a_i [m3i_pkg::ELEM],
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] r_i [m3i_pkg::ELEM],
  input  logic        singular_i,
  input  logic        saturated_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned ELEM = m3i_pkg::ELEM;

  typedef struct {
    logic [31:0] r [ELEM];
    logic        singular;
    logic        saturated;
  } inverse_t;

  inverse_t pending_inverses[$];
  int       fails = 0;

  // exact adjugate / determinant, rounded half away from zero, clamped
  function automatic inverse_t invert(input logic [31:0] a [ELEM]);
    inverse_t          res;
    logic signed [127:0] ae [ELEM];
    logic signed [127:0] cof [ELEM];
    logic signed [127:0] det;
    logic [127:0]        dmag, num, quo, rem, lim;
    logic                neg;
    for (int k = 0; k < ELEM; k++) ae[k] = $signed(a[k]);
    for (int k = 0; k < ELEM; k++)
      cof[k] = ae[m3i_pkg::COF_IDX[k][0]] * ae[m3i_pkg::COF_IDX[k][1]]
             - ae[m3i_pkg::COF_IDX[k][2]] * ae[m3i_pkg::COF_IDX[k][3]];
    det = ae[0] * cof[0] + ae[1] * cof[3] + ae[2] * cof[6];
    res.singular  = (det == 0);
    res.saturated = 1'b0;
    for (int k = 0; k < ELEM; k++) res.r[k] = '0;
    if (res.singular) return res;
    dmag = det < 0 ? -det : det;
    for (int k = 0; k < ELEM; k++) begin
      neg = (cof[k] < 0) != (det < 0);
      num = (cof[k] < 0 ? -cof[k] : cof[k]) << 32;
      quo = num / dmag;
      rem = num % dmag;
      if ((rem << 1) >= dmag) quo = quo + 1;
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (quo > lim) begin
        quo = lim;
        res.saturated = 1'b1;
      end
      res.r[k] = neg ? -quo[31:0] : quo[31:0];
    end
    return res;
  endfunction

  assign fail_count_o = fails;
  assign pending_o = pending_inverses.size();

  always @(posedge clk_i) begin
    inverse_t want;
    if (out_valid_i && out_ready_i) begin
      if (pending_inverses.size() == 0) begin
        $error("result word with no matrix outstanding");
        fails++;
      end else begin
        want = pending_inverses.pop_front();
        for (int k = 0; k < ELEM; k++)
          if (r_i[k] !== want.r[k]) begin
            $error("r%0d%0d: expected %h, got %h", k / 3, k % 3, want.r[k], r_i[k]);
            fails++;
          end
        if (singular_i !== want.singular) begin
          $error("singular: expected %b, got %b", want.singular, singular_i);
          fails++;
        end
        if (saturated_i !== want.saturated) begin
          $error("saturated: expected %b, got %b", want.saturated, saturated_i);
          fails++;
        end
      end
    end
    if (in_valid_i && in_ready_i) pending_inverses.push_back(invert(a_i));
  end

endmodule

// ===== test/testbench.sv =====
module testbench;

  localparam int unsigned ELEM = m3i_pkg::ELEM;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] a [ELEM];
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] r [ELEM];
  logic        singular_o, saturated_o;
  int          fail_count, pending;
  bit          quiet = 1'b0;   // stretches with no idling on either side

  localparam logic [31:0] ONE = 32'h0001_0000;

  initial for (int k = 0; k < ELEM; k++) a[k] = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  matrix3x3_inverse dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .a00_i(a[0]), .a01_i(a[1]), .a02_i(a[2]),
    .a10_i(a[3]), .a11_i(a[4]), .a12_i(a[5]),
    .a20_i(a[6]), .a21_i(a[7]), .a22_i(a[8]),
    .out_valid_o, .out_ready_i,
    .r00_o(r[0]), .r01_o(r[1]), .r02_o(r[2]),
    .r10_o(r[3]), .r11_o(r[4]), .r12_o(r[5]),
    .r20_o(r[6]), .r21_o(r[7]), .r22_o(r[8]),
    .singular_o, .saturated_o
  );

  matrix_inverse_checker checker_i (
    .clk_i, .in_valid_i, .in_ready_i(in_ready_o), .a_i(a),
    .out_valid_i(out_valid_o), .out_ready_i, .r_i(r),
    .singular_i(singular_o), .saturated_i(saturated_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // offer one matrix word after a random gap, hold it until taken
  task automatic send_matrix(input logic [31:0] m [ELEM]);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    a = m;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // value in +-range Q16.16 with random fraction
  function automatic logic [31:0] near(input int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // output side: random stall before each result word
  initial begin
    int gap;
    @(negedge clk_i);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
        out_ready_i = 1'b0;
        @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [31:0] m [ELEM];
    int          kind;
    #1 rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: identity, zero, extremes, negative det, saturation, rank deficit
    m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};                     send_matrix(m);
    m = '{default: '0};                                          send_matrix(m);
    m = '{default: 32'h7FFF_FFFF};                               send_matrix(m);
    m = '{default: 32'h8000_0000};                               send_matrix(m);
    m = '{32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, ONE};  send_matrix(m);
    m = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};          send_matrix(m);
    m = '{0, ONE, 0, ONE, 0, 0, 0, 0, ONE};                      send_matrix(m);
    m = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};                   send_matrix(m);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                            send_matrix(m);
    m = '{1, 0, 0, 0, -1, 0, 0, 0, 32'hFFFF_FFFF};               send_matrix(m);
    m = '{2 * ONE, 0, 0, 0, 4 * ONE, 0, 0, 0, 3 * ONE};          send_matrix(m);
    m = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
          7 * ONE, 8 * ONE, 9 * ONE};                            send_matrix(m);
    m = '{ONE, 2 * ONE, 3 * ONE, 0, ONE, 4 * ONE,
          5 * ONE, 6 * ONE, 0};                                  send_matrix(m);
    m = '{3, 0, 0, 0, 3, 0, 0, 0, 3};                            send_matrix(m);
    m = '{32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF};
    send_matrix(m);

    // random: mostly well-conditioned, some singular, some full-range bits
    for (int n = 0; n < 950; n++) begin
      if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      for (int k = 0; k < ELEM; k++) m[k] = $urandom();
      case (kind)
        0, 1: ;                                         // any bit pattern
        2, 3, 4: for (int k = 0; k < ELEM; k++) m[k] = near(4 * ONE);
        5: for (int k = 0; k < ELEM; k++) m[k] = near(16);
        6: begin                                        // duplicated row
          for (int k = 0; k < ELEM; k++) m[k] = near(8 * ONE);
          for (int k = 0; k < 3; k++) m[6 + k] = m[k];
        end
        7: begin                                        // diagonal, any scale
          for (int k = 0; k < ELEM; k++) if (k % 4 != 0) m[k] = '0;
        end
        8: for (int k = 0; k < ELEM; k++) m[k] = $signed(m[k]) >>> $urandom_range(0, 31);
        default: begin                                  // identity plus noise
          for (int k = 0; k < ELEM; k++) m[k] = near(256);
          for (int k = 0; k < ELEM; k += 4) m[k] = m[k] + ONE;
        end
      endcase
      send_matrix(m);
    end
    in_valid_i = 1'b0;
    quiet = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (m3i_pkg::TOTAL_LAT + 20) @(posedge clk_i);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
